### rtl/ult_pkg.sv
// Package with token types, codes and constants for the unit language tokenizer.
package ult_pkg;

  typedef enum logic [2:0] {
    M_IDLE,
    M_COMMENT,
    M_NAME,
    M_INT,
    M_DOT,
    M_FRAC,
    M_ERROR
  } mode_t;

  localparam logic [3:0] K_END    = 4'd0;
  localparam logic [3:0] K_NAME   = 4'd1;
  localparam logic [3:0] K_NUM    = 4'd2;
  localparam logic [3:0] K_DIM    = 4'd3;
  localparam logic [3:0] K_UNIT   = 4'd4;
  localparam logic [3:0] K_LET    = 4'd5;
  localparam logic [3:0] K_IN     = 4'd6;
  localparam logic [3:0] K_SEMI   = 4'd7;
  localparam logic [3:0] K_COLON  = 4'd8;
  localparam logic [3:0] K_COMMA  = 4'd9;
  localparam logic [3:0] K_EQ     = 4'd10;
  localparam logic [3:0] K_STAR   = 4'd11;
  localparam logic [3:0] K_SLASH  = 4'd12;
  localparam logic [3:0] K_LPAREN = 4'd13;
  localparam logic [3:0] K_RPAREN = 4'd14;
  localparam logic [3:0] K_ERR    = 4'd15;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam logic [47:0] INT_MAX48   = 48'hFFFF_FFFF_FFFF;
  localparam logic [2:0]  FRAC_DIGITS = 3'd5;
  // Reciprocal of 3125 scaled by 2^40; exact floor for the padded fraction range.
  localparam logic [28:0] FRAC_RECIP  = 29'd351843721;

  localparam int FIFO_DEPTH = 4;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] line;
    logic [15:0] col;
    logic [15:0] offset;
    logic [15:0] len;
    logic [47:0] ip;
    logic [15:0] fp;
    logic        last;
  } token_t;

  typedef struct packed {
    logic [1:0] count;
    token_t     tok0;
    token_t     tok1;
  } push_t;

  function automatic logic [13:0] frac_weight(input logic [2:0] cnt);
    logic [13:0] w;
    case (cnt)
      3'd0: w = 14'd10000;
      3'd1: w = 14'd1000;
      3'd2: w = 14'd100;
      3'd3: w = 14'd10;
      3'd4: w = 14'd1;
      default: w = 14'd0;
    endcase
    return w;
  endfunction

  function automatic logic [3:0] symbol_kind(input logic [7:0] b);
    logic [3:0] k;
    case (b)
      8'h3B: k = K_SEMI;
      8'h3A: k = K_COLON;
      8'h2C: k = K_COMMA;
      8'h3D: k = K_EQ;
      8'h2A: k = K_STAR;
      8'h2F: k = K_SLASH;
      8'h28: k = K_LPAREN;
      8'h29: k = K_RPAREN;
      default: k = K_END;
    endcase
    return k;
  endfunction

endpackage

### rtl/ult_lex_core.sv
// Lexer state registers and the per-beat token decision logic.
module ult_lex_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  logic               opcode,
  input  logic [7:0]         text_byte,
  output ult_pkg::push_t     push
);

  ult_pkg::mode_t mode, mode_next;
  logic        held_slash, held_slash_next;
  logic [15:0] position, position_next;
  logic [15:0] cur_line, cur_line_next;
  logic [15:0] cur_col, cur_col_next;
  logic [15:0] tok_line, tok_line_next;
  logic [15:0] tok_col, tok_col_next;
  logic [15:0] tok_offset, tok_offset_next;
  logic [47:0] int_accum, int_accum_next;
  logic [16:0] frac_pad, frac_pad_next;
  logic [2:0]  frac_count, frac_count_next;
  logic [15:0] word_len, word_len_next;
  logic [31:0] word_prefix, word_prefix_next;

  logic        is_ws, is_sym, is_dig;
  logic [3:0]  sym;
  logic [3:0]  dval;
  logic [51:0] int_sum;
  logic [47:0] int_step;
  logic [45:0] frac_prod;
  logic [3:0]  name_kind;
  ult_pkg::token_t name_tok, num_tok, numf_tok, err_tok, slash_tok, sym_tok, end_tok;
  ult_pkg::token_t flush_tok;
  logic        flush_v, sl_v, sym_v;

  assign is_ws  = (text_byte == 8'h20) || (text_byte >= 8'h09 && text_byte <= 8'h0D);
  assign sym    = ult_pkg::symbol_kind(text_byte);
  assign is_sym = (sym != ult_pkg::K_END);
  assign is_dig = (text_byte >= 8'h30) && (text_byte <= 8'h39);
  assign dval   = text_byte[3:0];

  assign int_sum  = ({4'd0, int_accum} << 3) + ({4'd0, int_accum} << 1) + {48'd0, dval};
  assign int_step = (int_sum > {4'd0, ult_pkg::INT_MAX48}) ? ult_pkg::INT_MAX48
                                                           : int_sum[47:0];
  assign frac_prod = {29'd0, frac_pad} * {17'd0, ult_pkg::FRAC_RECIP};

  always_comb begin
    if (word_len == 16'd3 && word_prefix == 32'h0064696D) begin
      name_kind = ult_pkg::K_DIM;
    end else if (word_len == 16'd4 && word_prefix == 32'h756E6974) begin
      name_kind = ult_pkg::K_UNIT;
    end else if (word_len == 16'd3 && word_prefix == 32'h006C6574) begin
      name_kind = ult_pkg::K_LET;
    end else if (word_len == 16'd2 && word_prefix == 32'h0000696E) begin
      name_kind = ult_pkg::K_IN;
    end else begin
      name_kind = ult_pkg::K_NAME;
    end
  end

  always_comb begin
    err_tok = '0;
    err_tok.kind = ult_pkg::K_ERR;
    err_tok.line = tok_line;
    err_tok.col = tok_col;
    err_tok.offset = tok_offset;
    name_tok = err_tok;
    name_tok.kind = name_kind;
    name_tok.len = (name_kind == ult_pkg::K_NAME) ? word_len : 16'd0;
    num_tok = err_tok;
    num_tok.kind = ult_pkg::K_NUM;
    num_tok.ip = int_accum;
    numf_tok = num_tok;
    numf_tok.fp = frac_prod[44:29];
    slash_tok = err_tok;
    slash_tok.kind = ult_pkg::K_SLASH;
    sym_tok = '0;
    sym_tok.kind = sym;
    sym_tok.line = cur_line;
    sym_tok.col = cur_col;
    sym_tok.offset = position;
    end_tok = sym_tok;
    end_tok.kind = ult_pkg::K_END;
  end

  always_comb begin
    logic go_idle;
    mode_next = mode;
    held_slash_next = held_slash;
    position_next = position;
    cur_line_next = cur_line;
    cur_col_next = cur_col;
    tok_line_next = tok_line;
    tok_col_next = tok_col;
    tok_offset_next = tok_offset;
    int_accum_next = int_accum;
    frac_pad_next = frac_pad;
    frac_count_next = frac_count;
    word_len_next = word_len;
    word_prefix_next = word_prefix;
    flush_v = 1'b0;
    flush_tok = err_tok;
    sl_v = 1'b0;
    sym_v = 1'b0;
    go_idle = 1'b0;
    push = '0;

    if (opcode == ult_pkg::OP_END) begin
      case (mode)
        ult_pkg::M_NAME: begin
          flush_v = 1'b1;
          flush_tok = name_tok;
        end
        ult_pkg::M_INT: begin
          flush_v = 1'b1;
          flush_tok = num_tok;
        end
        ult_pkg::M_DOT: begin
          flush_v = 1'b1;
        end
        ult_pkg::M_FRAC: begin
          flush_v = 1'b1;
          flush_tok = numf_tok;
        end
        ult_pkg::M_IDLE: begin
          flush_v = held_slash;
          flush_tok = slash_tok;
        end
        default: begin
          flush_v = 1'b0;
        end
      endcase
      push.count = flush_v ? 2'd2 : 2'd1;
      push.tok0 = flush_v ? flush_tok : end_tok;
      push.tok1 = end_tok;
      mode_next = ult_pkg::M_IDLE;
      held_slash_next = 1'b0;
      position_next = '0;
      cur_line_next = 16'd1;
      cur_col_next = 16'd1;
      tok_line_next = 16'd1;
      tok_col_next = 16'd1;
      tok_offset_next = '0;
      int_accum_next = '0;
      frac_pad_next = '0;
      frac_count_next = '0;
      word_len_next = '0;
      word_prefix_next = '0;
    end else begin
      case (mode)
        ult_pkg::M_ERROR: begin
          go_idle = 1'b0;
        end
        ult_pkg::M_COMMENT: begin
          if (text_byte == 8'h0A) begin
            mode_next = ult_pkg::M_IDLE;
          end
        end
        ult_pkg::M_NAME: begin
          if (!is_ws && !is_sym) begin
            word_prefix_next = (word_len < 16'd4) ? {word_prefix[23:0], text_byte}
                                                  : 32'hFFFF_FFFF;
            if (word_len != 16'hFFFF) begin
              word_len_next = word_len + 16'd1;
            end
          end else begin
            flush_v = 1'b1;
            flush_tok = name_tok;
            go_idle = 1'b1;
          end
        end
        ult_pkg::M_INT: begin
          if (is_dig) begin
            int_accum_next = int_step;
          end else if (text_byte == 8'h2E) begin
            mode_next = ult_pkg::M_DOT;
          end else begin
            flush_v = 1'b1;
            flush_tok = num_tok;
            go_idle = 1'b1;
          end
        end
        ult_pkg::M_DOT: begin
          if (is_dig) begin
            mode_next = ult_pkg::M_FRAC;
            frac_pad_next = {13'd0, dval} * {3'd0, ult_pkg::frac_weight(3'd0)};
            frac_count_next = 3'd1;
          end else begin
            flush_v = 1'b1;
            mode_next = ult_pkg::M_ERROR;
          end
        end
        ult_pkg::M_FRAC: begin
          if (is_dig) begin
            if (frac_count < ult_pkg::FRAC_DIGITS) begin
              frac_pad_next = frac_pad
                            + {13'd0, dval} * {3'd0, ult_pkg::frac_weight(frac_count)};
              frac_count_next = frac_count + 3'd1;
            end
          end else begin
            flush_v = 1'b1;
            flush_tok = numf_tok;
            go_idle = 1'b1;
          end
        end
        default: begin
          go_idle = 1'b1;
        end
      endcase

      if (go_idle) begin
        mode_next = ult_pkg::M_IDLE;
        if (held_slash && text_byte == 8'h2F) begin
          held_slash_next = 1'b0;
          mode_next = ult_pkg::M_COMMENT;
        end else begin
          sl_v = held_slash;
          held_slash_next = 1'b0;
          if (is_ws) begin
            held_slash_next = 1'b0;
          end else if (sym == ult_pkg::K_SLASH) begin
            held_slash_next = 1'b1;
            tok_line_next = cur_line;
            tok_col_next = cur_col;
            tok_offset_next = position;
          end else if (is_sym) begin
            sym_v = 1'b1;
          end else begin
            tok_line_next = cur_line;
            tok_col_next = cur_col;
            tok_offset_next = position;
            if (is_dig) begin
              mode_next = ult_pkg::M_INT;
              int_accum_next = {44'd0, dval};
              frac_pad_next = '0;
              frac_count_next = '0;
            end else begin
              mode_next = ult_pkg::M_NAME;
              word_len_next = 16'd1;
              word_prefix_next = {24'd0, text_byte};
            end
          end
        end
      end

      push.count = 2'({1'b0, flush_v} + {1'b0, sl_v} + {1'b0, sym_v});
      push.tok0 = flush_v ? flush_tok : (sl_v ? slash_tok : sym_tok);
      push.tok1 = (flush_v && sl_v) ? slash_tok : sym_tok;

      if (text_byte == 8'h0A) begin
        if (cur_line != 16'hFFFF) begin
          cur_line_next = cur_line + 16'd1;
        end
        cur_col_next = 16'd1;
      end else if (cur_col != 16'hFFFF) begin
        cur_col_next = cur_col + 16'd1;
      end
      if (position != 16'hFFFF) begin
        position_next = position + 16'd1;
      end
    end

    push.tok0.last = (push.count == 2'd1);
    push.tok1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= ult_pkg::M_IDLE;
      held_slash <= 1'b0;
      position <= '0;
      cur_line <= 16'd1;
      cur_col <= 16'd1;
      tok_line <= 16'd1;
      tok_col <= 16'd1;
      tok_offset <= '0;
      int_accum <= '0;
      frac_pad <= '0;
      frac_count <= '0;
      word_len <= '0;
      word_prefix <= '0;
    end else if (take) begin
      mode <= mode_next;
      held_slash <= held_slash_next;
      position <= position_next;
      cur_line <= cur_line_next;
      cur_col <= cur_col_next;
      tok_line <= tok_line_next;
      tok_col <= tok_col_next;
      tok_offset <= tok_offset_next;
      int_accum <= int_accum_next;
      frac_pad <= frac_pad_next;
      frac_count <= frac_count_next;
      word_len <= word_len_next;
      word_prefix <= word_prefix_next;
    end
  end

endmodule

### rtl/ult_out_fifo.sv
// Result queue that takes up to two tokens per cycle and hands out one.
module ult_out_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  ult_pkg::push_t  push,
  input  logic            rd,
  output logic            not_empty,
  output logic            room2,
  output logic [2:0]      fill,
  output ult_pkg::token_t head
);

  ult_pkg::token_t mem [ult_pkg::FIFO_DEPTH];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count;
  logic [1:0] n_in;

  assign n_in      = wr ? push.count : 2'd0;
  assign not_empty = (count != 3'd0);
  assign room2     = (count <= 3'd2);
  assign fill      = count;
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (n_in != 2'd0) begin
      mem[wr_ptr] <= push.tok0;
    end
    if (n_in == 2'd2) begin
      mem[wr_ptr + 2'd1] <= push.tok1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= wr_ptr + n_in;
      rd_ptr <= rd_ptr + {1'b0, rd};
      count <= count + {1'b0, n_in} - {2'b0, rd};
    end
  end

endmodule

### rtl/unit_language_tokenizer_unit.sv
// Top level of the streaming tokenizer: lexer core and token queue.
//
//  channel  direction  handshake                   payload
//  byte     in         byte_valid / byte_stall     opcode, text_byte
//  token    out        token_valid / token_stall   token_kind .. last
//
// One byte beat is taken per cycle while byte_stall is low; its tokens enter the queue at
// the same edge. A beat yields zero to two tokens, and the token port gives out one per
// cycle while token_stall is low. byte_stall rises while the four-entry queue has fewer
// than two free slots. Reset returns the lexer to line 1, column 1 and empties the queue.
module unit_language_tokenizer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic        opcode,
  input  logic [7:0]  text_byte,
  output logic        token_valid,
  input  logic        token_stall,
  output logic [3:0]  token_kind,
  output logic [15:0] start_line,
  output logic [15:0] start_col,
  output logic [15:0] start_offset,
  output logic [15:0] name_length,
  output logic [47:0] int_part,
  output logic [15:0] frac_part,
  output logic        last
);

  ult_pkg::push_t  push;
  ult_pkg::token_t head;
  logic take, room2, not_empty;
  logic [2:0] fill;

  assign byte_stall = !room2;
  assign take = byte_valid && room2;

  ult_lex_core u_core (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .opcode    (opcode),
    .text_byte (text_byte),
    .push      (push)
  );

  ult_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr        (take),
    .push      (push),
    .rd        (not_empty && !token_stall),
    .not_empty (not_empty),
    .room2     (room2),
    .fill      (fill),
    .head      (head)
  );

  assign token_valid  = not_empty;
  assign token_kind   = head.kind;
  assign start_line   = head.line;
  assign start_col    = head.col;
  assign start_offset = head.offset;
  assign name_length  = head.len;
  assign int_part     = head.ip;
  assign frac_part    = head.fp;
  assign last         = head.last;

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= 3'd4) else $error("token queue overflow");

  a_end_gives_token: assert property (@(posedge clk) disable iff (rst)
    take && opcode == ult_pkg::OP_END |=> token_valid)
    else $error("end of text produced no token");

  a_end_count: assert property (@(posedge clk) disable iff (rst)
    take && opcode == ult_pkg::OP_END |-> push.count != 2'd0)
    else $error("end of text beat pushed nothing");

endmodule
